FILE: sv/epd_pkg.sv
// Shared types and constants for the escaped packet deframer.
package epd_pkg;

  localparam int EPD_MAX_PAYLOAD = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE     = 3'd4;

  localparam logic [1:0] WSRC_RX   = 2'd0;
  localparam logic [1:0] WSRC_END  = 2'd1;
  localparam logic [1:0] WSRC_HELD = 2'd2;

  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_src;
    logic       hold;
    logic       set_kind;
    logic       kind;
    logic       clear_fill;
    logic       emit_start;
    logic       emit_trunc;
    logic       rd_en;
    logic       rd_next;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_esc;
    logic is_end_hi;
    logic is_end_lo;
    logic is_ds_hi;
    logic is_cs_hi;
    logic is_ds_lo;
    logic is_cs_lo;
    logic will_fill;
    logic is_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: sv/epd_ram.sv
// Generic single-port-write, registered-read RAM.
module epd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/epd_ctrl.sv
// Deframer controller: parse state machine and run emission sequencing.
module epd_ctrl import epd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DSTART   = 4'd1;
  localparam logic [3:0] ST_CSTART   = 4'd2;
  localparam logic [3:0] ST_BODY     = 4'd3;
  localparam logic [3:0] ST_ESC      = 4'd4;
  localparam logic [3:0] ST_ENDP     = 4'd5;
  localparam logic [3:0] ST_DISC     = 4'd6;
  localparam logic [3:0] ST_DISC_END = 4'd7;
  localparam logic [3:0] ST_DISC_ESC = 4'd8;
  localparam logic [3:0] ST_STORE2   = 4'd9;
  localparam logic [3:0] ST_EMIT_RD  = 4'd10;
  localparam logic [3:0] ST_EMIT_LD  = 4'd11;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic       acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign s_tready = (state != ST_STORE2) && (state != ST_EMIT_RD) && (state != ST_EMIT_LD);
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (stat.is_ds_hi) state_next = ST_DSTART;
          else if (stat.is_cs_hi) state_next = ST_CSTART;
        end
      end
      ST_DSTART, ST_CSTART: begin
        if (acc) begin
          if ((state == ST_DSTART) ? stat.is_ds_lo : stat.is_cs_lo) begin
            state_next     = ST_BODY;
            cmd.set_kind   = 1'b1;
            cmd.kind       = (state == ST_CSTART);
            cmd.clear_fill = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_BODY: begin
        if (acc) begin
          if (stat.is_esc) begin
            state_next = ST_ESC;
          end else if (stat.is_end_hi) begin
            state_next = ST_ENDP;
          end else begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_RX;
            if (stat.will_fill) begin
              cmd.emit_start = 1'b1;
              cmd.emit_trunc = 1'b1;
              ret_next       = ST_DISC;
              state_next     = ST_EMIT_RD;
            end
          end
        end
      end
      ST_ESC: begin
        if (acc) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WSRC_RX;
          if (stat.will_fill) begin
            cmd.emit_start = 1'b1;
            cmd.emit_trunc = 1'b1;
            ret_next       = ST_DISC;
            state_next     = ST_EMIT_RD;
          end else begin
            state_next = ST_BODY;
          end
        end
      end
      ST_ENDP: begin
        if (acc) begin
          if (stat.is_end_lo) begin
            cmd.emit_start = 1'b1;
            ret_next       = ST_IDLE;
            state_next     = ST_EMIT_RD;
          end else begin
            // broken end pair: keep the first end byte
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_END;
            cmd.hold   = 1'b1;
            if (stat.will_fill) begin
              cmd.emit_start = 1'b1;
              cmd.emit_trunc = 1'b1;
              ret_next       = stat.is_esc ? ST_DISC_ESC : ST_DISC;
              state_next     = ST_EMIT_RD;
            end else if (stat.is_esc) begin
              state_next = ST_ESC;
            end else begin
              state_next = ST_STORE2;
            end
          end
        end
      end
      ST_STORE2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WSRC_HELD;
        if (stat.will_fill) begin
          cmd.emit_start = 1'b1;
          cmd.emit_trunc = 1'b1;
          ret_next       = ST_DISC;
          state_next     = ST_EMIT_RD;
        end else begin
          state_next = ST_BODY;
        end
      end
      ST_DISC: begin
        if (acc && stat.is_end_hi) state_next = ST_DISC_END;
      end
      ST_DISC_END: begin
        if (acc) state_next = stat.is_end_lo ? ST_IDLE : ST_DISC;
      end
      ST_DISC_ESC: begin
        if (acc) state_next = ST_DISC;
      end
      ST_EMIT_RD: begin
        if (stat.out_free) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.load_out = 1'b1;
        if (stat.is_last) begin
          cmd.clear_fill = 1'b1;
          state_next     = ret;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/epd_dpath.sv
// Deframer datapath: config registers, byte compares, payload store, output register.
module epd_dpath import epd_pkg::*; #(
  parameter int MAX_PAYLOAD = EPD_MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            rx_byte,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam int FW = $clog2(MAX_PAYLOAD + 1);

  logic [15:0]   dat_open, dat_close, cmd_open, cmd_close;
  logic [7:0]    esc_mark;
  logic          kind;
  logic          trunc;
  logic [FW-1:0] fill;
  logic [AW-1:0] rd_idx;
  logic [7:0]    held;
  logic [15:0]   em;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic          empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      dat_open  <= '0;
      dat_close <= '0;
      cmd_open  <= '0;
      cmd_close <= '0;
      esc_mark  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DATA_START: dat_open  <= cfg_data;
        REG_DATA_END:   dat_close <= cfg_data;
        REG_CMD_START:  cmd_open  <= cfg_data;
        REG_CMD_END:    cmd_close <= cfg_data;
        REG_ESCAPE:     esc_mark  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign em = kind ? cmd_close : dat_close;

  always_comb begin
    case (cmd.wr_src)
      WSRC_END:  wdata = em[15:8];
      WSRC_HELD: wdata = held;
      default:   wdata = rx_byte;
    endcase
  end

  assign empty = (fill == '0);

  assign stat.is_esc    = (rx_byte == esc_mark);
  assign stat.is_end_hi = (rx_byte == em[15:8]);
  assign stat.is_end_lo = (rx_byte == em[7:0]);
  assign stat.is_ds_hi  = (rx_byte == dat_open[15:8]);
  assign stat.is_cs_hi  = (rx_byte == cmd_open[15:8]);
  assign stat.is_ds_lo  = (rx_byte == dat_open[7:0]);
  assign stat.is_cs_lo  = (rx_byte == cmd_open[7:0]);
  assign stat.will_fill = (fill == FW'(MAX_PAYLOAD - 1));
  assign stat.is_last   = empty || ((FW'(rd_idx) + FW'(1)) == fill);
  assign stat.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind     <= 1'b0;
      trunc    <= 1'b0;
      fill     <= '0;
      rd_idx   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.set_kind) kind <= cmd.kind;
      if (cmd.clear_fill) fill <= '0;
      else if (cmd.wr_en) fill <= fill + FW'(1);
      if (cmd.emit_start) begin
        trunc  <= cmd.emit_trunc;
        rd_idx <= '0;
      end else if (cmd.rd_next) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold) held <= rx_byte;
    if (cmd.load_out) begin
      m_tdata <= {2'b00, trunc, 4'(rd_idx), !empty, (empty ? 8'h00 : rdata)};
      m_tuser <= kind;
      m_tlast <= stat.is_last;
    end
  end

  epd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(fill[AW-1:0]),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(rd_idx),
    .rdata(rdata)
  );

endmodule

FILE: sv/escaped_packet_deframer.sv
// Input: one byte is taken per cycle while s_tready is high; a broken end pair may stall input in ST_STORE2.
// After the closing byte of a run is taken, its first result goes through ST_EMIT_RD and ST_EMIT_LD.
// Emission: each beat of a run is a store read in ST_EMIT_RD, then an output load in ST_EMIT_LD.
// Input stalls meanwhile; emission is paced by the single registered read port of the payload store.
// Reset: synchronous, clears config, parser and output valid; the store is not cleared.
module escaped_packet_deframer import epd_pkg::*; #(
  parameter int MAX_PAYLOAD = EPD_MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [7:0] payload_byte, [8] byte_present,
                                           // [12:9] byte_position, [13] truncated
  output logic                  m_tuser,   // [0] packet_kind
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  epd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  epd_dpath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx_byte  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("output load over a pending beat");

  a_trunc_full: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_start && cmd.emit_trunc |-> stat.will_fill && cmd.wr_en)
    else $error("truncated run without a full store");

  a_no_accept_emit: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.load_out && !cmd.rd_en)
    else $error("input accepted during run emission");

endmodule
